/* hw/rtl/ccvm_pkg.sv */
// Package: word types, constants and arithmetic helpers for the chase camera view matrix.
`timescale 1ns / 1ps
package ccvm_pkg;
  localparam int FRAC_BITS = 16;
  localparam int RSQRT_ITERS = 3;
  localparam int QDEPTH = 2;
  localparam logic [1:0] REG_BACK = 2'd0;
  localparam logic [1:0] REG_SIDE = 2'd1;
  localparam logic [1:0] REG_UP = 2'd2;
  localparam logic [63:0] Q30_THREE = 64'd3 << 30;
  localparam logic [63:0] GUESS_LOW = 64'd912680550;
  localparam logic [63:0] GUESS_HIGH = 64'd644245094;

  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] look_x;
    logic signed [31:0] look_y;
    logic signed [31:0] look_z;
    logic signed [31:0] right_x;
    logic signed [31:0] right_y;
    logic signed [31:0] right_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
  } in_word_t;

  typedef struct packed {
    logic [1:0] row_index;
    logic signed [31:0] col_right;
    logic signed [31:0] col_up;
    logic signed [31:0] col_look;
    logic last_row;
  } out_word_t;

  // Front result: camera position plus raw look and right.
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] look_x;
    logic signed [31:0] look_y;
    logic signed [31:0] look_z;
    logic signed [31:0] right_x;
    logic signed [31:0] right_y;
    logic signed [31:0] right_z;
  } job_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) return 32'sh7fffffff;
    if (v < -68'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] fmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p >>> FRAC_BITS;
  endfunction
endpackage

/* hw/rtl/ccvm_front.sv */
// Front end: accepts poses, computes the offset camera position, queues jobs.
`timescale 1ns / 1ps
module ccvm_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  ccvm_pkg::in_word_t in_data,
  input  logic signed [31:0] off_back,
  input  logic signed [31:0] off_side,
  input  logic signed [31:0] off_up,
  output logic job_valid,
  input  logic job_take,
  output ccvm_pkg::job_t job
);
  import ccvm_pkg::*;
  // stage 1: products
  logic s1_v_r;
  in_word_t s1_d_r;
  logic signed [63:0] pb_r [3];
  logic signed [63:0] ps_r [3];
  logic signed [63:0] pu_r [3];
  job_t q_r [QDEPTH];
  logic [1:0] cnt_r;
  logic rd_r, wr_r;
  logic [1:0] occ;
  logic push, pop;
  job_t j;

  assign occ = cnt_r + {1'b0, s1_v_r};
  assign in_stall = (occ >= 2'(QDEPTH));
  assign pop = job_valid && job_take;
  assign push = s1_v_r;

  always_comb begin
    j.pos_x = sat32(68'(s1_d_r.target_x) - 68'(pb_r[0]) + 68'(ps_r[0]) + 68'(pu_r[0]));
    j.pos_y = sat32(68'(s1_d_r.target_y) - 68'(pb_r[1]) + 68'(ps_r[1]) + 68'(pu_r[1]));
    j.pos_z = sat32(68'(s1_d_r.target_z) - 68'(pb_r[2]) + 68'(ps_r[2]) + 68'(pu_r[2]));
    j.look_x = s1_d_r.look_x;
    j.look_y = s1_d_r.look_y;
    j.look_z = s1_d_r.look_z;
    j.right_x = s1_d_r.right_x;
    j.right_y = s1_d_r.right_y;
    j.right_z = s1_d_r.right_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      cnt_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      s1_v_r <= in_valid && !in_stall;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
    end
    if (in_valid && !in_stall) begin
      s1_d_r <= in_data;
      pb_r[0] <= fmul(off_back, in_data.look_x);
      pb_r[1] <= fmul(off_back, in_data.look_y);
      pb_r[2] <= fmul(off_back, in_data.look_z);
      ps_r[0] <= fmul(off_side, in_data.right_x);
      ps_r[1] <= fmul(off_side, in_data.right_y);
      ps_r[2] <= fmul(off_side, in_data.right_z);
      pu_r[0] <= fmul(off_up, in_data.up_x);
      pu_r[1] <= fmul(off_up, in_data.up_y);
      pu_r[2] <= fmul(off_up, in_data.up_z);
    end
    if (push) q_r[wr_r] <= j;
  end

  assign job_valid = (cnt_r != 2'd0);
  assign job = q_r[rd_r];
endmodule

/* hw/rtl/ccvm_back.sv */
// Back end: normalizes look, builds up and right, translation, emits four rows.
`timescale 1ns / 1ps
module ccvm_back (
  input  logic clk,
  input  logic rst_n,
  input  logic job_valid,
  output logic job_take,
  input  ccvm_pkg::job_t job,
  output logic out_valid,
  input  logic out_stall,
  output ccvm_pkg::out_word_t out_data
);
  import ccvm_pkg::*;
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_L2 = 5'd1;   // len2 sum
  localparam logic [4:0] ST_EXP = 5'd2;  // exponent, mantissa
  localparam logic [4:0] ST_NY2 = 5'd3;  // y*y
  localparam logic [4:0] ST_NT = 5'd4;   // m*y2
  localparam logic [4:0] ST_NY = 5'd5;   // y*(3-t)
  localparam logic [4:0] ST_SC = 5'd6;   // scale components
  localparam logic [4:0] ST_CR = 5'd7;   // cross products
  localparam logic [4:0] ST_CRS = 5'd8;  // cross subtract
  localparam logic [4:0] ST_DOT = 5'd9;  // dot products
  localparam logic [4:0] ST_DOTS = 5'd10;
  localparam logic [4:0] ST_EMIT = 5'd11;
  localparam logic [4:0] ST_SQ = 5'd12;  // squares

  logic [4:0] st_r;
  logic [1:0] pass_r; // 0 look norm, 1 up norm / cross, 2 right cross
  logic [2:0] it_r;
  logic [1:0] row_r;
  job_t jb_r;
  logic signed [31:0] v_r [3];
  logic signed [31:0] nl_r [3];
  logic signed [31:0] nu_r [3];
  logic signed [31:0] nr_r [3];
  logic signed [31:0] tr_r [3];
  logic signed [63:0] pa_r [3];
  logic signed [63:0] pb_r [3];
  logic [63:0] sq_r [3];
  logic [63:0] len2_r;
  logic [5:0] s_r;
  logic [63:0] m_r, y_r, y2_r, t_r;
  logic [5:0] e;
  logic [63:0] prod;
  logic out_v_r;
  out_word_t out_r;
  logic [5:0] sh;
  logic signed [95:0] sc [3];

  always_comb begin
    e = '0;
    for (int i = 0; i < 64; i++) if (len2_r[i]) e = 6'(i);
  end
  assign sh = 6'(30 - FRAC_BITS) + {1'b0, s_r[5:1]};
  always_comb
    for (int i = 0; i < 3; i++) sc[i] = (96'(v_r[i]) * $signed({1'b0, y_r[31:0]})) >>> sh;
  assign prod = m_r[31:0] * y2_r[31:0];

  assign job_take = (st_r == ST_IDLE) && job_valid;
  assign out_valid = out_v_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      out_v_r <= 1'b0;
      pass_r <= '0;
      it_r <= '0;
      row_r <= '0;
    end else begin
      if (out_v_r && !out_stall && st_r != ST_EMIT) out_v_r <= 1'b0;
      case (st_r)
        ST_IDLE: if (job_valid) begin
          jb_r <= job;
          v_r[0] <= job.look_x;
          v_r[1] <= job.look_y;
          v_r[2] <= job.look_z;
          pass_r <= 2'd0;
          st_r <= ST_SQ;
        end
        ST_SQ: begin
          for (int i = 0; i < 3; i++) sq_r[i] <= 64'(v_r[i] * v_r[i]);
          st_r <= ST_L2;
        end
        ST_L2: begin
          len2_r <= sq_r[0] + sq_r[1] + sq_r[2];
          st_r <= ST_EXP;
        end
        ST_EXP: begin
          s_r <= {e[5:1], 1'b0};
          if ({e[5:1], 1'b0} >= 6'd30) m_r <= len2_r >> ({e[5:1], 1'b0} - 6'd30);
          else m_r <= len2_r << (6'd30 - {e[5:1], 1'b0});
          y_r <= (({e[5:1], 1'b0} >= 6'd30 ? len2_r >> ({e[5:1], 1'b0} - 6'd30)
                   : len2_r << (6'd30 - {e[5:1], 1'b0})) < (64'd2 << 30))
                 ? GUESS_LOW : GUESS_HIGH;
          it_r <= '0;
          st_r <= (len2_r == 64'd0) ? ST_SC : ST_NY2;
        end
        ST_NY2: begin
          y2_r <= (y_r[31:0] * y_r[31:0]) >> 30;
          st_r <= ST_NT;
        end
        ST_NT: begin
          t_r <= ((prod >> 30) > Q30_THREE) ? Q30_THREE : (prod >> 30);
          st_r <= ST_NY;
        end
        ST_NY: begin
          y_r <= (y_r[31:0] * (Q30_THREE[31:0] - t_r[31:0])) >> 31;
          it_r <= it_r + 3'd1;
          st_r <= (it_r == 3'(RSQRT_ITERS - 1)) ? ST_SC : ST_NY2;
        end
        ST_SC: begin
          for (int i = 0; i < 3; i++) begin
            if (len2_r == 64'd0) begin
              if (pass_r == 2'd0) nl_r[i] <= '0; else nu_r[i] <= '0;
            end else if (pass_r == 2'd0) nl_r[i] <= sat32(sc[i][67:0]);
            else nu_r[i] <= sat32(sc[i][67:0]);
          end
          pass_r <= pass_r + 2'd1;
          st_r <= ST_CR;
        end
        ST_CR: begin
          if (pass_r == 2'd1) begin
            pa_r[0] <= fmul(nl_r[1], jb_r.right_z); pb_r[0] <= fmul(nl_r[2], jb_r.right_y);
            pa_r[1] <= fmul(nl_r[2], jb_r.right_x); pb_r[1] <= fmul(nl_r[0], jb_r.right_z);
            pa_r[2] <= fmul(nl_r[0], jb_r.right_y); pb_r[2] <= fmul(nl_r[1], jb_r.right_x);
          end else begin
            pa_r[0] <= fmul(nu_r[1], nl_r[2]); pb_r[0] <= fmul(nu_r[2], nl_r[1]);
            pa_r[1] <= fmul(nu_r[2], nl_r[0]); pb_r[1] <= fmul(nu_r[0], nl_r[2]);
            pa_r[2] <= fmul(nu_r[0], nl_r[1]); pb_r[2] <= fmul(nu_r[1], nl_r[0]);
          end
          st_r <= ST_CRS;
        end
        ST_CRS: begin
          for (int i = 0; i < 3; i++) begin
            if (pass_r == 2'd1) v_r[i] <= sat32(68'(pa_r[i]) - 68'(pb_r[i]));
            else nr_r[i] <= sat32(68'(pa_r[i]) - 68'(pb_r[i]));
          end
          st_r <= (pass_r == 2'd1) ? ST_SQ : ST_DOT;
        end
        ST_DOT: begin
          pa_r[0] <= fmul(jb_r.pos_x, nr_r[0]) + fmul(jb_r.pos_y, nr_r[1]);
          pb_r[0] <= fmul(jb_r.pos_z, nr_r[2]);
          pa_r[1] <= fmul(jb_r.pos_x, nu_r[0]) + fmul(jb_r.pos_y, nu_r[1]);
          pb_r[1] <= fmul(jb_r.pos_z, nu_r[2]);
          pa_r[2] <= fmul(jb_r.pos_x, nl_r[0]) + fmul(jb_r.pos_y, nl_r[1]);
          pb_r[2] <= fmul(jb_r.pos_z, nl_r[2]);
          st_r <= ST_DOTS;
        end
        ST_DOTS: begin
          for (int i = 0; i < 3; i++) tr_r[i] <= sat32(-(68'(pa_r[i]) + 68'(pb_r[i])));
          row_r <= '0;
          st_r <= ST_EMIT;
        end
        ST_EMIT: if (!out_v_r || !out_stall) begin
          out_v_r <= 1'b1;
          out_r.row_index <= row_r;
          out_r.col_right <= (row_r == 2'd3) ? tr_r[0] : nr_r[row_r];
          out_r.col_up <= (row_r == 2'd3) ? tr_r[1] : nu_r[row_r];
          out_r.col_look <= (row_r == 2'd3) ? tr_r[2] : nl_r[row_r];
          out_r.last_row <= (row_r == 2'd3);
          row_r <= row_r + 2'd1;
          if (row_r == 2'd3) st_r <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end
endmodule

/* hw/rtl/chase_camera_view_matrix_top.sv */
// Top level: configuration registers, front end, job queue and back end.
`timescale 1ns / 1ps
// Chase camera view matrix. Each accepted pose word yields four result words,
// rows 0..3, with last_row set on the translation row. The back end runs one
// pose at a time through a shared multiply datapath: two inverse square root
// passes of RSQRT_ITERS Newton steps each, plus cross and dot products and the
// four emitted rows (a zero-length vector skips its Newton steps). A two-entry
// queue lets the front end take new poses while the back end works. Offsets
// are to be written on cfg_ only while idle; the block does not enforce it.
module chase_camera_view_matrix_top (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  ccvm_pkg::in_word_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output ccvm_pkg::out_word_t out_data,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import ccvm_pkg::*;
  logic signed [31:0] back_r, side_r, up_r;
  logic jv, jt;
  job_t jb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      back_r <= '0;
      side_r <= '0;
      up_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BACK: back_r <= cfg_data;
        REG_SIDE: side_r <= cfg_data;
        REG_UP: up_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ccvm_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .off_back(back_r), .off_side(side_r), .off_up(up_r),
    .job_valid(jv), .job_take(jt), .job(jb)
  );

  ccvm_back u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(jv), .job_take(jt), .job(jb),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );
endmodule
